// ===== src/acdp_pkg.sv =====
package acdp_pkg;

    // Field widths of the anchor and result channels.
    localparam int COORD_W = 28;
    localparam int COUNT_W = 24;
    localparam int SCORE_W = 32;
    localparam int PRED_W  = 11;

    // Window offsets and coordinate sums that include them.
    localparam int OFFSET_W = 32;
    localparam int SUM_W    = OFFSET_W + 1;

    // APB register port.
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    // Default history depth.
    localparam int MAX_ANCHORS_DEF = 1024;

    // Scoring constants.
    localparam int MATCH_WEIGHT    = 10;
    localparam int LINK_BASE_COST  = 100;
    localparam int LINK_SPAN_LIMIT = 10000;
    localparam int DIAG_SPAN_LIMIT = 500;

    // Register indexes (byte address divided by four).
    typedef logic [APB_AW-3:0] reg_idx_t;
    localparam reg_idx_t REG_SAME_REGION = 2'd0;
    localparam reg_idx_t REG_Q_OFFSET    = 2'd1;
    localparam reg_idx_t REG_R_OFFSET    = 2'd2;

    // One history entry as kept in the anchor memory.
    typedef struct packed {
        logic [COORD_W-1:0]        q_end;
        logic [COORD_W-1:0]        r_start;
        logic [COORD_W-1:0]        r_end;
        logic signed [SCORE_W-1:0] score;
    } acdp_entry_t;

    // The current anchor as seen by the link pipeline.
    typedef struct packed {
        logic [COORD_W-1:0]        q_begin;
        logic [COORD_W-1:0]        q_finish;
        logic [COORD_W-1:0]        r_begin;
        logic [COORD_W-1:0]        r_finish;
        logic signed [SCORE_W-1:0] own;
        logic [OFFSET_W-1:0]       q_off;
        logic [OFFSET_W-1:0]       r_off;
        logic                      diag_en;
    } acdp_ctx_t;

    // One scored link candidate leaving the pipeline.
    typedef struct packed {
        logic                      valid;
        logic                      ok;
        logic signed [SCORE_W-1:0] score;
    } acdp_cand_t;

endpackage

// ===== src/acdp_anchor_if.sv =====
interface acdp_anchor_if import acdp_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               first_anchor;
    logic [COORD_W-1:0] q_begin;
    logic [COORD_W-1:0] q_finish;
    logic [COORD_W-1:0] r_begin;
    logic [COORD_W-1:0] r_finish;
    logic [COUNT_W-1:0] match_count;
    logic [COUNT_W-1:0] mismatch_count;
    logic [COUNT_W-1:0] gap_base_count;

    modport source (
        output valid, first_anchor, q_begin, q_finish, r_begin, r_finish,
               match_count, mismatch_count, gap_base_count,
        input  ready
    );

    modport sink (
        input  valid, first_anchor, q_begin, q_finish, r_begin, r_finish,
               match_count, mismatch_count, gap_base_count,
        output ready
    );

endinterface

// ===== src/acdp_result_if.sv =====
interface acdp_result_if import acdp_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] chain_score;
    logic signed [PRED_W-1:0]  predecessor;
    logic                      anchor_rejected;

    modport source (
        output valid, chain_score, predecessor, anchor_rejected,
        input  ready
    );

    modport sink (
        input  valid, chain_score, predecessor, anchor_rejected,
        output ready
    );

endinterface

// ===== src/anchor_chaining_dp.sv =====
// The history holds n anchors (0 to MAX_ANCHORS); during the scan the
// history memory is read one entry per cycle through its single read port,
// newest first. A new anchor is taken only once the previous one has reached
// the output register; a finished result waits there while the next request
// is taken.
// Reset clears the control and output registers and empties the history at once; no clearing pass.
module anchor_chaining_dp import acdp_pkg::*; #(
    parameter int MAX_ANCHORS = MAX_ANCHORS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    acdp_anchor_if.sink       anchor,
    acdp_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IW     = $clog2(MAX_ANCHORS);
    localparam int CW     = $clog2(MAX_ANCHORS + 1);
    localparam int TW     = SCORE_W;
    localparam int SPAN_W = COORD_W + 1;
    localparam int DW     = SUM_W + 2;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ANCHORS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP_SUM,
        ST_PREP_OWN,
        ST_PREP_DIAG,
        ST_SCAN,
        ST_STORE,
        ST_DONE
    } state_t;

    // Control and configuration.
    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       n_reg;
    logic [CW-1:0]       remain_reg;
    logic                same_region_reg;
    logic [OFFSET_W-1:0] q_off_reg;
    logic [OFFSET_W-1:0] r_off_reg;
    logic                rd_valid_reg;

    // Current anchor.
    logic [COORD_W-1:0] qb_reg;
    logic [COORD_W-1:0] qf_reg;
    logic [COORD_W-1:0] rb_reg;
    logic [COORD_W-1:0] rf_reg;
    logic [COUNT_W-1:0] mc_reg;
    logic [COUNT_W-1:0] mm_reg;
    logic [COUNT_W-1:0] gb_reg;

    // Per-anchor setup.
    logic signed [TW-1:0]      twice_reg;
    logic signed [SCORE_W-1:0] own_reg;
    logic [SUM_W-1:0]          aq_lo_reg;
    logic [SUM_W-1:0]          aq_hi_reg;
    logic [SUM_W-1:0]          ar_lo_reg;
    logic [SUM_W-1:0]          ar_hi_reg;
    logic signed [SPAN_W-1:0]  span_q_reg;
    logic signed [SPAN_W-1:0]  span_r_reg;
    logic [SUM_W-1:0]          ovl_reg;
    logic                      rejected_reg;

    // Running best link.
    logic signed [SCORE_W-1:0] best_reg;
    logic [IW-1:0]             pred_idx_reg;
    logic                      has_pred_reg;

    // Output register.
    logic                      out_valid_reg;
    logic signed [SCORE_W-1:0] out_score_reg;
    logic signed [PRED_W-1:0]  out_pred_reg;
    logic                      out_rejected_reg;

    // History memory and its registered read port.
    acdp_entry_t mem [MAX_ANCHORS];
    acdp_entry_t rd_data_reg;
    logic [IW-1:0] rd_idx_reg;

    // Combinational values.
    logic                      in_fire;
    logic                      cfg_write;
    reg_idx_t                  cfg_idx;
    logic                      rd_en;
    logic [CW-1:0]             remain_dec;
    logic [IW-1:0]             rd_addr;
    logic                      mem_we;
    acdp_entry_t               mem_wdata;
    logic signed [TW-1:0]      mc_x;
    logic signed [TW-1:0]      mm_x;
    logic signed [TW-1:0]      gb_x;
    logic signed [TW-1:0]      twice_next;
    logic signed [TW-1:0]      round_sum;
    logic [SUM_W-1:0]          anc_hi;
    logic [SUM_W-1:0]          anc_lo;
    logic signed [DW-1:0]      slack_q;
    logic signed [DW-1:0]      slack_r;
    logic                      rejected_next;
    logic                      link_busy;
    logic                      scan_done;
    logic                      better;
    logic                      out_load;
    logic [PRED_W+IW-1:0]      pred_ext;
    acdp_ctx_t                 ctx;
    acdp_cand_t                cand;
    logic [IW-1:0]             cand_idx;

    // Handshakes.
    assign anchor.ready = (state_reg == ST_IDLE);
    assign in_fire      = anchor.valid && (state_reg == ST_IDLE);
    assign pready       = 1'b1;
    assign cfg_idx      = paddr[APB_AW-1:2];
    assign cfg_write    = psel && penable && pwrite && pready;

    // Register read-back.
    always_comb
    begin
        case (cfg_idx)
            REG_SAME_REGION: prdata = {{(APB_DW-1){1'b0}}, same_region_reg};
            REG_Q_OFFSET:    prdata = q_off_reg;
            REG_R_OFFSET:    prdata = r_off_reg;
            default:         prdata = '0;
        endcase
    end

    // Own score: 2*(10*matches) - 2*mismatches - gaps, halved toward zero.
    always_comb
    begin
        mc_x       = TW'(mc_reg);
        mm_x       = TW'(mm_reg);
        gb_x       = TW'(gb_reg);
        twice_next = mc_x * TW'(2 * MATCH_WEIGHT) - (mm_x <<< 1) - gb_x;
        round_sum  = twice_reg + {{(TW-1){1'b0}}, twice_reg[TW-1]};
    end

    // Self-diagonal overlap of the anchor and the rejection test.
    always_comb
    begin
        anc_hi        = (aq_hi_reg < ar_hi_reg) ? aq_hi_reg : ar_hi_reg;
        anc_lo        = (aq_lo_reg > ar_lo_reg) ? aq_lo_reg : ar_lo_reg;
        slack_q       = DW'(span_q_reg) - DW'(ovl_reg);
        slack_r       = DW'(span_r_reg) - DW'(ovl_reg);
        rejected_next = same_region_reg && (slack_r < DW'(DIAG_SPAN_LIMIT)) &&
                        (slack_q < DW'(DIAG_SPAN_LIMIT));
    end

    // Scan control: newest entry first, one read per cycle.
    always_comb
    begin
        remain_dec = remain_reg - CW'(1);
        rd_addr    = remain_dec[IW-1:0];
        rd_en      = (state_reg == ST_SCAN) && (remain_reg != '0);
        scan_done  = (remain_reg == '0) && !rd_valid_reg && !link_busy;
        better     = cand.valid && cand.ok && (cand.score >= best_reg);
    end

    // Write-back of the finished anchor.
    always_comb
    begin
        mem_we            = (state_reg == ST_STORE) && (n_reg < CNT_MAX);
        mem_wdata.q_end   = qf_reg;
        mem_wdata.r_start = rb_reg;
        mem_wdata.r_end   = rf_reg;
        mem_wdata.score   = best_reg;
        out_load          = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
        pred_ext          = {{PRED_W{1'b0}}, pred_idx_reg};
    end

    // Current anchor as seen by the link pipeline.
    always_comb
    begin
        ctx.q_begin  = qb_reg;
        ctx.q_finish = qf_reg;
        ctx.r_begin  = rb_reg;
        ctx.r_finish = rf_reg;
        ctx.own      = own_reg;
        ctx.q_off    = q_off_reg;
        ctx.r_off    = r_off_reg;
        ctx.diag_en  = same_region_reg;
    end

    acdp_link #(
        .IW (IW)
    ) u_link (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (rd_valid_reg),
        .req_idx   (rd_idx_reg),
        .req_entry (rd_data_reg),
        .ctx       (ctx),
        .cand      (cand),
        .cand_idx  (cand_idx),
        .busy      (link_busy)
    );

    // History memory: written at most once per anchor, read during the scan only.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[n_reg[IW-1:0]] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // Current anchor and setup arithmetic.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            qb_reg <= anchor.q_begin;
            qf_reg <= anchor.q_finish;
            rb_reg <= anchor.r_begin;
            rf_reg <= anchor.r_finish;
            mc_reg <= anchor.match_count;
            mm_reg <= anchor.mismatch_count;
            gb_reg <= anchor.gap_base_count;
        end
        if (state_reg == ST_PREP_SUM)
        begin
            twice_reg  <= twice_next;
            aq_lo_reg  <= SUM_W'(q_off_reg) + SUM_W'(qb_reg);
            aq_hi_reg  <= SUM_W'(q_off_reg) + SUM_W'(qf_reg);
            ar_lo_reg  <= SUM_W'(r_off_reg) + SUM_W'(rb_reg);
            ar_hi_reg  <= SUM_W'(r_off_reg) + SUM_W'(rf_reg);
            span_q_reg <= SPAN_W'(qf_reg) - SPAN_W'(qb_reg);
            span_r_reg <= SPAN_W'(rf_reg) - SPAN_W'(rb_reg);
        end
        if (state_reg == ST_PREP_OWN)
        begin
            own_reg <= round_sum >>> 1;
            ovl_reg <= (anc_hi > anc_lo) ? (anc_hi - anc_lo) : '0;
        end
    end

    // Sequencer, configuration, running best and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            n_reg            <= '0;
            remain_reg       <= '0;
            same_region_reg  <= 1'b0;
            q_off_reg        <= '0;
            r_off_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            rejected_reg     <= 1'b0;
            best_reg         <= '0;
            pred_idx_reg     <= '0;
            has_pred_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_score_reg    <= '0;
            out_pred_reg     <= '0;
            out_rejected_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;

            // Register writes.
            if (cfg_write)
            begin
                case (cfg_idx)
                    REG_SAME_REGION: same_region_reg <= pwdata[0];
                    REG_Q_OFFSET:    q_off_reg       <= pwdata;
                    REG_R_OFFSET:    r_off_reg       <= pwdata;
                    default:         ;
                endcase
            end

            // The output register empties when the result is taken.
            if (out_load)
            begin
                out_valid_reg    <= 1'b1;
                out_score_reg    <= best_reg;
                out_pred_reg     <= has_pred_reg ? $signed(pred_ext[PRED_W-1:0]) : '1;
                out_rejected_reg <= rejected_reg;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        n_reg     <= anchor.first_anchor ? '0 : count_reg;
                        state_reg <= ST_PREP_SUM;
                    end
                end
                ST_PREP_SUM:
                begin
                    state_reg <= ST_PREP_OWN;
                end
                ST_PREP_OWN:
                begin
                    state_reg <= ST_PREP_DIAG;
                end
                ST_PREP_DIAG:
                begin
                    rejected_reg <= rejected_next;
                    best_reg     <= rejected_next ? '0 : own_reg;
                    has_pred_reg <= 1'b0;
                    remain_reg   <= rejected_next ? '0 : n_reg;
                    state_reg    <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        remain_reg <= remain_dec;
                    end
                    // Older entries come later, so a tie moves to the older one.
                    if (better)
                    begin
                        best_reg     <= cand.score;
                        pred_idx_reg <= cand_idx;
                        has_pred_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    count_reg <= mem_we ? (n_reg + CW'(1)) : n_reg;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.chain_score     = out_score_reg;
    assign result.predecessor     = out_pred_reg;
    assign result.anchor_rejected = out_rejected_reg;

`ifndef SYNTHESIS
    // The history never holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("history count exceeds depth");

    // Only written entries of the current history are read.
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (CW'(rd_addr) < n_reg))
        else $error("history read beyond stored anchors");

    // The write-back waits until every candidate has been scored.
    a_store_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE) |-> (!link_busy && !rd_valid_reg))
        else $error("write-back while link pipeline busy");

    // A chosen predecessor is a stored anchor.
    a_pred_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && has_pred_reg) |-> (CW'(pred_idx_reg) < n_reg))
        else $error("predecessor outside history");

    // A rejected anchor never links.
    a_reject_no_link: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && rejected_reg) |-> !has_pred_reg)
        else $error("rejected anchor has a predecessor");
`endif

endmodule

// ===== src/acdp_link.sv =====
// Four-stage pipeline that scores one stored anchor as a predecessor of the
// current anchor. One history entry enters per cycle.
module acdp_link import acdp_pkg::*; #(
    parameter int IW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic [IW-1:0] req_idx,
    input  acdp_entry_t   req_entry,
    input  acdp_ctx_t     ctx,
    output acdp_cand_t    cand,
    output logic [IW-1:0] cand_idx,
    output logic          busy
);

    localparam int PEN_W  = COORD_W + 1;
    localparam int BASE_W = SCORE_W + 1;
    localparam int RAW_W  = SCORE_W + 3;
    localparam logic [COORD_W-1:0] SPAN_LIMIT = COORD_W'(LINK_SPAN_LIMIT);

    // Clamp a wide signed sum into the score range.
    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [RAW_W-1:0] v
    );
        logic all_same;
        all_same = (v[RAW_W-1:SCORE_W-1] == {(RAW_W-SCORE_W+1){1'b0}}) ||
                   (v[RAW_W-1:SCORE_W-1] == {(RAW_W-SCORE_W+1){1'b1}});
        if (all_same)
        begin
            return v[SCORE_W-1:0];
        end
        else if (v[RAW_W-1])
        begin
            return {1'b1, {(SCORE_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(SCORE_W-1){1'b1}}};
        end
    endfunction

    // Stage valid bits.
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic s5_valid_reg;

    // Stage two: clipped gap starts and ordering checks.
    logic                      s2_ok_reg;
    logic [IW-1:0]             s2_idx_reg;
    logic [COORD_W-1:0]        s2_dq_reg;
    logic [COORD_W-1:0]        s2_dr_reg;
    logic [COORD_W-1:0]        s2_cqs_reg;
    logic [COORD_W-1:0]        s2_crs_reg;
    logic [COORD_W-1:0]        s2_pqe_reg;
    logic [COORD_W-1:0]        s2_pre_reg;
    logic signed [SCORE_W-1:0] s2_score_reg;

    // Stage three: gap extremes and genomic coordinates of the gap.
    logic                      s3_ok_reg;
    logic [IW-1:0]             s3_idx_reg;
    logic [COORD_W-1:0]        s3_mi_reg;
    logic [COORD_W-1:0]        s3_diff_reg;
    logic [SUM_W-1:0]          s3_aq_lo_reg;
    logic [SUM_W-1:0]          s3_aq_hi_reg;
    logic [SUM_W-1:0]          s3_ar_lo_reg;
    logic [SUM_W-1:0]          s3_ar_hi_reg;
    logic signed [SCORE_W-1:0] s3_score_reg;

    // Stage four: gap penalty, diagonal test and base sum.
    logic                      s4_ok_reg;
    logic [IW-1:0]             s4_idx_reg;
    logic [PEN_W-1:0]          s4_pen_reg;
    logic signed [BASE_W-1:0]  s4_base_reg;

    // Stage five: saturated link score.
    logic                      s5_ok_reg;
    logic [IW-1:0]             s5_idx_reg;
    logic signed [SCORE_W-1:0] s5_score_reg;

    // Combinational values of each stage.
    logic [COORD_W-1:0]        cqs;
    logic [COORD_W-1:0]        crs;
    logic                      order_ok;
    logic                      dq_gt;
    logic                      near;
    logic [SUM_W-1:0]          gap_hi;
    logic [SUM_W-1:0]          gap_lo;
    logic                      on_diag;
    logic [PEN_W-1:0]          penalty;
    logic signed [BASE_W-1:0]  base;
    logic signed [RAW_W-1:0]   raw;

    // Gap starts are clipped to the end of the stored anchor.
    always_comb
    begin
        cqs      = (ctx.q_begin < req_entry.q_end) ? req_entry.q_end : ctx.q_begin;
        crs      = (ctx.r_begin < req_entry.r_end) ? req_entry.r_end : ctx.r_begin;
        order_ok = (req_entry.q_end < ctx.q_finish) && (req_entry.r_end < ctx.r_finish) &&
                   (req_entry.r_start < ctx.r_begin);
    end

    // Larger and smaller gap; both must stay inside the link span.
    always_comb
    begin
        dq_gt = s2_dq_reg > s2_dr_reg;
        near  = (s2_dq_reg < SPAN_LIMIT) && (s2_dr_reg < SPAN_LIMIT);
    end

    // A link whose gap crosses the self-diagonal is rejected.
    always_comb
    begin
        gap_hi  = (s3_aq_hi_reg < s3_ar_hi_reg) ? s3_aq_hi_reg : s3_ar_hi_reg;
        gap_lo  = (s3_aq_lo_reg > s3_ar_lo_reg) ? s3_aq_lo_reg : s3_ar_lo_reg;
        on_diag = ctx.diag_en && (gap_hi > gap_lo);
        penalty = PEN_W'(s3_mi_reg) + PEN_W'(LINK_BASE_COST) + PEN_W'(s3_diff_reg >> 1);
        base    = BASE_W'(s3_score_reg) + BASE_W'(ctx.own);
    end

    // Link score before the best-so-far compare.
    always_comb
    begin
        raw = RAW_W'(s4_base_reg) - RAW_W'($signed({1'b0, s4_pen_reg}));
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= req_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        s2_ok_reg    <= order_ok;
        s2_idx_reg   <= req_idx;
        s2_dq_reg    <= cqs - req_entry.q_end;
        s2_dr_reg    <= crs - req_entry.r_end;
        s2_cqs_reg   <= cqs;
        s2_crs_reg   <= crs;
        s2_pqe_reg   <= req_entry.q_end;
        s2_pre_reg   <= req_entry.r_end;
        s2_score_reg <= req_entry.score;

        s3_ok_reg    <= s2_ok_reg && near;
        s3_idx_reg   <= s2_idx_reg;
        s3_mi_reg    <= dq_gt ? s2_dr_reg : s2_dq_reg;
        s3_diff_reg  <= dq_gt ? (s2_dq_reg - s2_dr_reg) : (s2_dr_reg - s2_dq_reg);
        s3_aq_lo_reg <= SUM_W'(ctx.q_off) + SUM_W'(s2_pqe_reg);
        s3_aq_hi_reg <= SUM_W'(ctx.q_off) + SUM_W'(s2_cqs_reg);
        s3_ar_lo_reg <= SUM_W'(ctx.r_off) + SUM_W'(s2_pre_reg);
        s3_ar_hi_reg <= SUM_W'(ctx.r_off) + SUM_W'(s2_crs_reg);
        s3_score_reg <= s2_score_reg;

        s4_ok_reg    <= s3_ok_reg && !on_diag;
        s4_idx_reg   <= s3_idx_reg;
        s4_pen_reg   <= penalty;
        s4_base_reg  <= base;

        s5_ok_reg    <= s4_ok_reg;
        s5_idx_reg   <= s4_idx_reg;
        s5_score_reg <= sat_score(raw);
    end

    assign cand.valid = s5_valid_reg;
    assign cand.ok    = s5_ok_reg;
    assign cand.score = s5_score_reg;
    assign cand_idx   = s5_idx_reg;
    assign busy       = s2_valid_reg || s3_valid_reg || s4_valid_reg || s5_valid_reg;

endmodule

// ===== sim/acdp_checker.sv =====
module acdp_checker import acdp_pkg::*; #(
    parameter int HIST_DEPTH = MAX_ANCHORS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    acdp_anchor_if            anchor,
    acdp_result_if            result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                fail_count,
    output int                outstanding,
    output int                anchors_seen,
    output int                rejected_seen,
    output int                linked_seen,
    output int                saturated_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SCORE_HI = 64'sd2147483647;
    localparam longint SCORE_LO = -64'sd2147483648;
    localparam int     PRINT_CAP = 40;

    typedef struct {
        logic signed [SCORE_W-1:0] score;
        logic signed [PRED_W-1:0]  pred;
        logic                      rejected;
    } chain_result_t;

    // Results still owed by the block, oldest first.
    chain_result_t pending_chains[$];

    // Shadow of the register file.
    logic                diag_check_en;
    logic [OFFSET_W-1:0] q_offset;
    logic [OFFSET_W-1:0] r_offset;

    // Shadow of the anchor history.
    int unsigned               hist_count;
    logic [COORD_W-1:0]        hist_q_end   [HIST_DEPTH];
    logic [COORD_W-1:0]        hist_r_start [HIST_DEPTH];
    logic [COORD_W-1:0]        hist_r_end   [HIST_DEPTH];
    logic signed [SCORE_W-1:0] hist_score   [HIST_DEPTH];

    int results_checked;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("MISMATCH at %0t ns, result %0d: %s", $time, results_checked, msg);
        fail_count++;
    endtask

    function automatic longint sat_score(input longint v);
        if (v > SCORE_HI)
            return SCORE_HI;
        if (v < SCORE_LO)
            return SCORE_LO;
        return v;
    endfunction

    // Overlap of a query span and a reference span once both are placed on the genome.
    function automatic longint genome_overlap(input longint qlo, input longint qhi,
                                              input longint rlo, input longint rhi);
        longint oq;
        longint orf;
        longint hi;
        longint lo;
        oq  = longint'(q_offset);
        orf = longint'(r_offset);
        hi  = (oq + qhi < orf + rhi) ? oq + qhi : orf + rhi;
        lo  = (oq + qlo > orf + rlo) ? oq + qlo : orf + rlo;
        return (hi - lo > 0) ? hi - lo : 0;
    endfunction

    // Scores one anchor against the history and records it, as the block should.
    function automatic chain_result_t chain_anchor(
        input logic first, input longint qb, input longint qf, input longint rb,
        input longint rf, input longint mc, input longint mm, input longint gb);
        chain_result_t r;
        int unsigned   n;
        longint        own;
        longint        best;
        longint        ov;
        longint        pqe;
        longint        prs;
        longint        pre;
        longint        cqs;
        longint        crs;
        longint        dq;
        longint        dr;
        longint        ma;
        longint        mi;
        longint        sco;
        int            pred;
        logic          rej;

        if (first)
            hist_count = 0;
        if (hist_count > HIST_DEPTH)
            hist_count = HIST_DEPTH;
        n = hist_count;

        // Own score; SV division already truncates toward zero.
        own  = sat_score((2 * MATCH_WEIGHT * mc - 2 * mm - gb) / 2);
        best = 0;
        pred = -1;
        rej  = 1'b0;

        if (diag_check_en)
        begin
            ov = genome_overlap(qb, qf, rb, rf);
            if ((rf - rb) - ov < DIAG_SPAN_LIMIT && (qf - qb) - ov < DIAG_SPAN_LIMIT)
                rej = 1'b1;
        end

        // Newest candidate first, so a tie leaves the oldest one standing.
        if (!rej)
        begin
            best = own;
            for (int j = int'(n) - 1; j >= 0; j--)
            begin
                pqe = longint'(hist_q_end[j]);
                prs = longint'(hist_r_start[j]);
                pre = longint'(hist_r_end[j]);
                cqs = (qb < pqe) ? pqe : qb;
                crs = (rb < pre) ? pre : rb;
                if (pqe >= qf || pre >= rf || prs >= rb)
                    continue;
                dq = cqs - pqe;
                dr = crs - pre;
                ma = (dq > dr) ? dq : dr;
                mi = (dq > dr) ? dr : dq;
                if (ma >= LINK_SPAN_LIMIT)
                    continue;
                if (diag_check_en && genome_overlap(pqe, cqs, pre, crs) >= 1)
                    continue;
                sco = longint'(hist_score[j]) + own - mi - (LINK_BASE_COST + (ma - mi) / 2);
                sco = sat_score(sco);
                if (sco >= best)
                begin
                    best = sco;
                    pred = j;
                end
            end
        end

        // A full history still scores new anchors but keeps no more of them.
        if (n < HIST_DEPTH)
        begin
            hist_q_end[n]   = qf[COORD_W-1:0];
            hist_r_start[n] = rb[COORD_W-1:0];
            hist_r_end[n]   = rf[COORD_W-1:0];
            hist_score[n]   = best[SCORE_W-1:0];
            hist_count      = n + 1;
        end

        anchors_seen++;
        if (rej)
            rejected_seen++;
        if (pred >= 0)
            linked_seen++;
        if (best == SCORE_HI)
            saturated_seen++;

        r.score    = best[SCORE_W-1:0];
        r.pred     = pred[PRED_W-1:0];
        r.rejected = rej;
        return r;
    endfunction

    // Watch the register port and both channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        chain_result_t want;
        if (!rst_n)
        begin
            diag_check_en   = 1'b0;
            q_offset        = '0;
            r_offset        = '0;
            hist_count      = 0;
            pending_chains.delete();
            fail_count      = 0;
            outstanding     = 0;
            anchors_seen    = 0;
            rejected_seen   = 0;
            linked_seen     = 0;
            saturated_seen  = 0;
            results_checked = 0;
        end
        else
        begin
            if (psel === 1'b1 && penable === 1'b1 && pwrite === 1'b1 && pready === 1'b1)
            begin
                case (reg_idx_t'(paddr[APB_AW-1:2]))
                    REG_SAME_REGION: diag_check_en = pwdata[0];
                    REG_Q_OFFSET:    q_offset      = pwdata;
                    REG_R_OFFSET:    r_offset      = pwdata;
                    default:         ;
                endcase
            end

            if (anchor.valid === 1'b1 && anchor.ready === 1'b1)
                pending_chains.push_back(chain_anchor(anchor.first_anchor,
                    longint'(anchor.q_begin), longint'(anchor.q_finish),
                    longint'(anchor.r_begin), longint'(anchor.r_finish),
                    longint'(anchor.match_count), longint'(anchor.mismatch_count),
                    longint'(anchor.gap_base_count)));

            if (result.valid === 1'b1 && result.ready === 1'b1)
            begin
                if (pending_chains.size() == 0)
                    report_mismatch($sformatf("result with no request pending, score %0d",
                                              result.chain_score));
                else
                begin
                    want = pending_chains.pop_front();
                    if (result.chain_score !== want.score)
                        report_mismatch($sformatf("chain_score %0d, expected %0d",
                                                  result.chain_score, want.score));
                    if (result.predecessor !== want.pred)
                        report_mismatch($sformatf("predecessor %0d, expected %0d",
                                                  result.predecessor, want.pred));
                    if (result.anchor_rejected !== want.rejected)
                        report_mismatch($sformatf("anchor_rejected %b, expected %b",
                                                  result.anchor_rejected, want.rejected));
                end
                results_checked++;
            end

            outstanding = pending_chains.size();
        end
    end

endmodule

// ===== sim/anchor_chaining_dp_tb.sv =====
module anchor_chaining_dp_tb;

    import acdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A small history keeps the full-store case cheap to reach.
    localparam int     HIST_DEPTH   = 64;
    localparam int     IDLE_MAX     = 16;
    localparam int     DRAIN_CYCLES = HIST_DEPTH + 40;
    localparam int     HOLD_CYCLES  = 600;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     PHASE_ITEMS  = 80;
    localparam int     COORD_TOP    = 2**COORD_W - 1;
    localparam int     COUNT_TOP    = 2**COUNT_W - 1;
    localparam longint COORD_MAX    = longint'(COORD_TOP);

    typedef struct packed {
        logic               first_anchor;
        logic [COORD_W-1:0] q_begin;
        logic [COORD_W-1:0] q_finish;
        logic [COORD_W-1:0] r_begin;
        logic [COORD_W-1:0] r_finish;
        logic [COUNT_W-1:0] match_count;
        logic [COUNT_W-1:0] mismatch_count;
        logic [COUNT_W-1:0] gap_base_count;
    } anchor_req_t;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int outstanding;
    int anchors_seen;
    int rejected_seen;
    int linked_seen;
    int saturated_seen;

    int   cycle_count = 0;
    int   results_taken;
    int   settings_applied = 0;
    logic sink_hold;
    logic src_no_idle;
    logic sink_no_idle;

    // Current register values, needed to aim anchors at the diagonal.
    logic                cfg_mode  = 1'b0;
    logic [OFFSET_W-1:0] cfg_q_off = '0;
    logic [OFFSET_W-1:0] cfg_r_off = '0;

    // Ends of the previous anchor in the current well-formed set.
    longint chain_q;
    longint chain_r;
    logic   heavy_set;

    acdp_anchor_if anchor_bus ();
    acdp_result_if result_bus ();

    anchor_chaining_dp #(
        .MAX_ANCHORS (HIST_DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .anchor  (anchor_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    acdp_checker #(
        .HIST_DEPTH (HIST_DEPTH)
    ) chain_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .anchor         (anchor_bus),
        .result         (result_bus),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .anchors_seen   (anchors_seen),
        .rejected_seen  (rejected_seen),
        .linked_seen    (linked_seen),
        .saturated_seen (saturated_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls per request, paused entirely during a hold-off.
    initial
    begin
        int unsigned gap_left;
        result_bus.ready = 1'b0;
        results_taken    = 0;
        gap_left         = $urandom_range(0, IDLE_MAX);
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (sink_hold || gap_left != 0)
                result_bus.ready <= 1'b0;
            else
                result_bus.ready <= 1'b1;
            if (!sink_hold && gap_left != 0)
                gap_left--;
            @(posedge clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                results_taken++;
                gap_left = sink_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
            end
        end
    end

    // Two long hold-offs so the block fills up and pushes back on requests.
    initial
    begin
        sink_hold = 1'b0;
        wait (results_taken >= 150);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
        wait (results_taken >= 420);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
    end

    // Switch idling off on either side now and then.
    initial
    begin
        src_no_idle  = 1'b0;
        sink_no_idle = 1'b0;
        forever
        begin
            repeat ($urandom_range(300, 1500)) @(posedge clk);
            src_no_idle  = ($urandom_range(0, 3) == 0);
            sink_no_idle = ($urandom_range(0, 3) == 0);
        end
    end

    task automatic offer_anchor(input anchor_req_t a);
        int unsigned gap;
        gap = src_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        repeat (gap)
        begin
            @(negedge clk);
            anchor_bus.valid <= 1'b0;
        end
        @(negedge clk);
        anchor_bus.valid          <= 1'b1;
        anchor_bus.first_anchor   <= a.first_anchor;
        anchor_bus.q_begin        <= a.q_begin;
        anchor_bus.q_finish       <= a.q_finish;
        anchor_bus.r_begin        <= a.r_begin;
        anchor_bus.r_finish       <= a.r_finish;
        anchor_bus.match_count    <= a.match_count;
        anchor_bus.mismatch_count <= a.mismatch_count;
        anchor_bus.gap_base_count <= a.gap_base_count;
        do
            @(posedge clk);
        while (anchor_bus.ready !== 1'b1);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering, let every result come back, then give the block time to settle.
    task automatic wait_drained();
        @(negedge clk);
        anchor_bus.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic mode, input logic [OFFSET_W-1:0] q_off,
                                input logic [OFFSET_W-1:0] r_off);
        logic [APB_DW-1:0] mode_word;
        wait_drained();
        // Upper bits of the mode register are don't-care; keep them noisy.
        mode_word    = $urandom();
        mode_word[0] = mode;
        write_register(REG_SAME_REGION, mode_word);
        write_register(REG_Q_OFFSET, q_off);
        write_register(REG_R_OFFSET, r_off);
        cfg_mode  = mode;
        cfg_q_off = q_off;
        cfg_r_off = r_off;
        settings_applied++;
    endtask

    function automatic anchor_req_t mk_anchor(input logic first, input int qb, input int qf,
                                              input int rb, input int rf, input int mc,
                                              input int mm, input int gb);
        anchor_req_t a;
        a.first_anchor   = first;
        a.q_begin        = qb;
        a.q_finish       = qf;
        a.r_begin        = rb;
        a.r_finish       = rf;
        a.match_count    = mc;
        a.mismatch_count = mm;
        a.gap_base_count = gb;
        return a;
    endfunction

    function automatic logic [COORD_W-1:0] to_coord(input longint v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_MAX[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    function automatic void start_chain();
        chain_q   = longint'($urandom_range(0, 2**27));
        chain_r   = chain_q + longint'($urandom_range(0, 100000)) - 50000;
        heavy_set = ($urandom_range(0, 7) == 0);
    endfunction

    // Next anchor of a colinear set: mostly short gaps, some near the span
    // limit, some overlapping the previous anchor.
    function automatic anchor_req_t chained_anchor(input logic first);
        anchor_req_t a;
        int unsigned sel;
        longint      gap;
        longint      qb;
        longint      rb;
        longint      qlen;
        longint      rlen;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            gap = longint'($urandom_range(0, 2500));
        else if (sel < 8)
            gap = longint'($urandom_range(8000, 12000));
        else
            gap = -longint'($urandom_range(0, 300));
        qlen = longint'($urandom_range(20, 1500));
        rlen = qlen + longint'($urandom_range(0, 100)) - 50;
        qb   = chain_q + gap;
        rb   = chain_r + gap + longint'($urandom_range(0, 600)) - 300;
        a.first_anchor = first;
        a.q_begin      = to_coord(qb);
        a.q_finish     = to_coord(qb + qlen);
        a.r_begin      = to_coord(rb);
        a.r_finish     = to_coord(rb + rlen);
        if (heavy_set)
        begin
            a.match_count    = $urandom_range(2**23, COUNT_TOP);
            a.mismatch_count = $urandom_range(0, 2**16);
            a.gap_base_count = $urandom_range(0, 2**16);
        end
        else
        begin
            a.match_count    = $urandom_range(0, int'(qlen));
            a.mismatch_count = $urandom_range(0, int'(qlen) / 10);
            a.gap_base_count = $urandom_range(0, 41);
        end
        chain_q = qb + qlen;
        chain_r = rb + rlen;
        return a;
    endfunction

    // An anchor placed on or near the genomic diagonal under the current offsets.
    function automatic anchor_req_t diagonal_anchor(input logic first);
        anchor_req_t a;
        longint      shift;
        longint      jit;
        longint      rb;
        longint      rf;
        a     = chained_anchor(first);
        shift = longint'(cfg_q_off) - longint'(cfg_r_off);
        if ($urandom_range(0, 1) == 0)
            jit = longint'($urandom_range(0, 600)) - 300;
        else
            jit = longint'($urandom_range(0, 6000)) - 3000;
        rb = longint'(a.q_begin) + shift + jit;
        rf = longint'(a.q_finish) + shift + jit + longint'($urandom_range(0, 200)) - 100;
        if (rb >= 0 && rf >= 0 && rb <= COORD_MAX && rf <= COORD_MAX)
        begin
            a.r_begin  = rb[COORD_W-1:0];
            a.r_finish = rf[COORD_W-1:0];
            chain_r    = rf;
        end
        return a;
    endfunction

    function automatic anchor_req_t noise_anchor();
        anchor_req_t a;
        a.first_anchor   = $urandom_range(0, 1);
        a.q_begin        = $urandom();
        a.q_finish       = $urandom();
        a.r_begin        = $urandom();
        a.r_finish       = $urandom();
        a.match_count    = $urandom();
        a.mismatch_count = $urandom();
        a.gap_base_count = $urandom();
        return a;
    endfunction

    // Sets of mostly well-formed anchors, with some noise and reversed spans.
    task automatic run_random_phase(input int n_items, input bit force_long);
        int          set_left;
        int unsigned kind;
        logic        first;
        anchor_req_t a;
        set_left = 0;
        for (int i = 0; i < n_items; i++)
        begin
            first = 1'b0;
            if (set_left == 0)
            begin
                if (force_long && i == 0)
                    set_left = HIST_DEPTH + 6;
                else if ($urandom_range(0, 19) == 0)
                    set_left = $urandom_range(HIST_DEPTH + 1, HIST_DEPTH + 8);
                else
                    set_left = $urandom_range(1, 20);
                start_chain();
                first = 1'b1;
            end
            set_left--;
            kind = $urandom_range(0, 99);
            if (kind < 6)
                a = noise_anchor();
            else if (cfg_mode && kind < 30)
                a = diagonal_anchor(first);
            else
                a = chained_anchor(first);
            // Reversed coordinates: a finish below its begin.
            if (kind >= 6 && kind < 10)
            begin
                if ($urandom_range(0, 1) == 0)
                    {a.q_begin, a.q_finish} = {a.q_finish, a.q_begin};
                else
                    {a.r_begin, a.r_finish} = {a.r_finish, a.r_begin};
            end
            offer_anchor(a);
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        anchor_bus.valid          = 1'b0;
        anchor_bus.first_anchor   = 1'b0;
        anchor_bus.q_begin        = '0;
        anchor_bus.q_finish       = '0;
        anchor_bus.r_begin        = '0;
        anchor_bus.r_finish       = '0;
        anchor_bus.match_count    = '0;
        anchor_bus.mismatch_count = '0;
        anchor_bus.gap_base_count = '0;
        chain_q   = 0;
        chain_r   = 0;
        heavy_set = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: no diagonal rejection, zero offsets.
        // Zero anchor, then every field at its top.
        offer_anchor(mk_anchor(1, 0, 0, 0, 0, 0, 0, 0));
        offer_anchor(mk_anchor(0, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP,
                               COUNT_TOP, COUNT_TOP, COUNT_TOP));
        // Most negative own score, then an odd gap count that truncates.
        offer_anchor(mk_anchor(1, 100, 200, 100, 200, 0, COUNT_TOP, COUNT_TOP));
        offer_anchor(mk_anchor(0, 300, 400, 300, 400, 5, 0, 3));
        // Two identical predecessors: the older one must win the tie.
        offer_anchor(mk_anchor(1, 1000, 1100, 1000, 1100, 100, 0, 0));
        offer_anchor(mk_anchor(0, 1000, 1100, 1000, 1100, 100, 0, 0));
        offer_anchor(mk_anchor(0, 1200, 1300, 1200, 1300, 100, 0, 0));
        // Gap of exactly the span limit, then one just below it.
        offer_anchor(mk_anchor(0, 11300, 11400, 11300, 11400, 80, 2, 1));
        offer_anchor(mk_anchor(0, 21399, 21500, 21300, 21400, 90, 1, 0));
        // Reversed query span, reversed reference span, then links across them.
        offer_anchor(mk_anchor(0, 30000, 29000, 29500, 29600, 300, 4, 2));
        offer_anchor(mk_anchor(0, 39000, 39500, 40000, 39000, 200, 0, 7));
        offer_anchor(mk_anchor(0, 40000, 40100, 40500, 40600, 50, 1, 1));
        // Overlaps the previous anchor, so the clipped query gap is zero.
        offer_anchor(mk_anchor(0, 40050, 40200, 40550, 40700, 60, 0, 0));

        // Diagonal rejection on, offsets at zero.
        apply_config(1'b1, '0, '0);
        // Diagonal anchor, and one shifted off it whose overlap still gets it rejected.
        offer_anchor(mk_anchor(1, 5000, 5400, 5000, 5400, 400, 0, 0));
        offer_anchor(mk_anchor(0, 6000, 6600, 6100, 6700, 600, 0, 0));
        // Off the diagonal, but every link to it crosses the diagonal.
        offer_anchor(mk_anchor(0, 7000, 8000, 9000, 10000, 1000, 0, 0));
        // A clean link that stays above the diagonal.
        offer_anchor(mk_anchor(0, 8500, 9000, 10500, 11000, 500, 0, 0));
        // Spans just long enough to escape rejection.
        offer_anchor(mk_anchor(0, 12000, 13000, 12500, 13500, 900, 3, 3));

        // Random phases over a spread of register settings.
        apply_config(1'b0, $urandom(), $urandom());
        run_random_phase(PHASE_ITEMS, 1'b1);
        apply_config(1'b1, '0, '0);
        run_random_phase(PHASE_ITEMS, 1'b0);
        apply_config(1'b1, '1, '1);
        run_random_phase(PHASE_ITEMS, 1'b0);
        apply_config(1'b1, 5000 + $urandom_range(0, 20000), $urandom_range(0, 5000));
        run_random_phase(PHASE_ITEMS, 1'b1);
        apply_config(1'b1, '0, '1);
        run_random_phase(PHASE_ITEMS, 1'b0);
        apply_config(1'b0, '1, '0);
        run_random_phase(PHASE_ITEMS, 1'b0);
        cfg_q_off = $urandom();
        apply_config(1'b1, cfg_q_off, cfg_q_off + $urandom_range(0, 100000));
        run_random_phase(PHASE_ITEMS, 1'b0);

        wait_drained();

        $display("Ran %0d anchors under %0d register settings in %0d cycles.",
                 anchors_seen, settings_applied + 1, cycle_count);
        $display("Of these, %0d were rejected on the diagonal, %0d linked, %0d saturated.",
                 rejected_seen, linked_seen, saturated_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
        begin
            if (outstanding != 0)
                $display("%0d expected results never arrived", outstanding);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/acdp_pkg.sv
src/acdp_anchor_if.sv
src/acdp_result_if.sv
src/acdp_link.sv
src/anchor_chaining_dp.sv
sim/acdp_checker.sv
sim/anchor_chaining_dp_tb.sv
